/* hw/rtl/stps_pkg.sv */
// Shared types, codes and a helper function for the stipple and tile pixel select block.
// Used by the top level, the remainder pipeline and the port checker.
// No dependencies.
package stps_pkg;

	// Input operation codes.
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_DRAW = 1'b1;

	// Result action codes.
	localparam logic [1:0] ACT_NONE  = 2'd0;
	localparam logic [1:0] ACT_COLOR = 2'd1;
	localparam logic [1:0] ACT_TILE  = 2'd2;

	// Fill mode codes.
	localparam logic [1:0] FM_STIPPLE = 2'd0;
	localparam logic [1:0] FM_OPAQUE  = 2'd1;
	localparam logic [1:0] FM_TILE    = 2'd2;
	localparam logic [1:0] FM_UNUSED  = 2'd3;

	// Configuration register indexes.
	localparam logic [2:0] CFG_FILL_MODE  = 3'd0;
	localparam logic [2:0] CFG_ORIGIN_X   = 3'd1;
	localparam logic [2:0] CFG_ORIGIN_Y   = 3'd2;
	localparam logic [2:0] CFG_WIDTH      = 3'd3;
	localparam logic [2:0] CFG_HEIGHT     = 3'd4;
	localparam logic [2:0] CFG_FOREGROUND = 3'd5;
	localparam logic [2:0] CFG_BACKGROUND = 3'd6;

	// Remainder pipeline shape: 16 dividend bits, four bits retired per stage.
	localparam int MOD_STAGES = 4;
	localparam int MOD_STEP   = 4;

	// Accept to result strobe, in cycles.
	localparam int OUT_LATENCY = 8;

	// Stipple word address before range check: py * pitch + column word.
	localparam int IDX_W = 15;

	// What an item will produce once the pattern lookup is done.
	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_FG,
		KIND_PATTERN
	} kind_t;

	// Per-item control that rides alongside the remainder pipeline.
	typedef struct packed {
		logic        load;
		kind_t       kind;
		logic [7:0]  windex;
		logic [15:0] wdata;
	} side_t;

	// One restoring step: shift in a dividend bit and subtract the divisor if it fits.
	function automatic logic [6:0] mod_step(input logic [6:0] r, input logic b,
			input logic [6:0] d);
		logic [7:0] t;
		t = {r, b};
		if (t >= {1'b0, d}) begin
			mod_step = 7'(t - {1'b0, d});
		end else begin
			mod_step = t[6:0];
		end
	endfunction

endpackage

/* hw/rtl/stps_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module stps_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/stps_mod_pipe.sv */
// Pipelined remainder of two 16-bit offsets by the pattern width and height.
// Depends on stps_pkg for the stage shape and the restoring step.
module stps_mod_pipe
	import stps_pkg::*;
(
	input  logic        clk,
	input  logic [15:0] dvd_x,
	input  logic [15:0] dvd_y,
	input  logic [6:0]  div_x,
	input  logic [6:0]  div_y,
	output logic [6:0]  rem_x,
	output logic [6:0]  rem_y
);

	logic [6:0]  rx_s  [MOD_STAGES];
	logic [6:0]  ry_s  [MOD_STAGES];
	logic [15:0] dvx_s [MOD_STAGES];
	logic [15:0] dvy_s [MOD_STAGES];

	for (genvar k = 0; k < MOD_STAGES; k++) begin : g_stage
		logic [6:0]  rx_in, ry_in, rx_nxt, ry_nxt;
		logic [15:0] dx_in, dy_in;

		if (k == 0) begin : g_first
			assign rx_in = '0;
			assign ry_in = '0;
			assign dx_in = dvd_x;
			assign dy_in = dvd_y;
		end else begin : g_next
			assign rx_in = rx_s[k-1];
			assign ry_in = ry_s[k-1];
			assign dx_in = dvx_s[k-1];
			assign dy_in = dvy_s[k-1];
		end

		// Retire this stage's dividend bits, most significant first.
		always_comb begin
			rx_nxt = rx_in;
			ry_nxt = ry_in;
			for (int j = 0; j < MOD_STEP; j++) begin
				rx_nxt = mod_step(rx_nxt, dx_in[15 - k*MOD_STEP - j], div_x);
				ry_nxt = mod_step(ry_nxt, dy_in[15 - k*MOD_STEP - j], div_y);
			end
		end

		always_ff @(posedge clk) begin
			rx_s[k]  <= rx_nxt;
			ry_s[k]  <= ry_nxt;
			dvx_s[k] <= dx_in;
			dvy_s[k] <= dy_in;
		end
	end

	assign rem_x = rx_s[MOD_STAGES-1];
	assign rem_y = ry_s[MOD_STAGES-1];

endmodule

/* hw/rtl/stipple_tile_pixel_select.sv */
// Stipple and tile fill pattern unit: one result word per accepted word.
// Throughput is one word per cycle; busy stays low and there is no stall on either side.
// Latency: the input register, 4 remainder stages, one address stage,
// the stipple RAM read, the output register.
// Reset clears configuration and pipeline valid bits; the stipple store is not cleared.
// Depends on stps_pkg, stps_mod_pipe and stps_ram.
module stipple_tile_pixel_select
	import stps_pkg::*;
#(
	parameter int WORD_BITS          = 16,
	parameter int MAX_PATTERN_WIDTH  = 64,
	parameter int MAX_PATTERN_HEIGHT = 64,
	parameter int STIPPLE_DEPTH      = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               operation,
	input  logic signed [15:0] point_x,
	input  logic signed [15:0] point_y,
	input  logic               clip_visible,
	input  logic [7:0]         word_index,
	input  logic [15:0]        word_data,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_wdata,
	output logic               done,
	output logic [1:0]         action,
	output logic [31:0]        color,
	output logic [5:0]         tile_x,
	output logic [5:0]         tile_y
);

	localparam int AW = (STIPPLE_DEPTH > 1) ? $clog2(STIPPLE_DEPTH) : 1;
	localparam int BW = $clog2(WORD_BITS);
	localparam int SIDE_LAST = MOD_STAGES + 1;

	// Configuration registers.
	logic [1:0]         fill_mode_q;
	logic signed [15:0] origin_x_q, origin_y_q;
	logic [6:0]         width_q, height_q;
	logic [31:0]        fg_q, bg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_mode_q <= '0;
			origin_x_q  <= '0;
			origin_y_q  <= '0;
			width_q     <= '0;
			height_q    <= '0;
			fg_q        <= '0;
			bg_q        <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FILL_MODE:  fill_mode_q <= cfg_wdata[1:0];
				CFG_ORIGIN_X:   origin_x_q  <= cfg_wdata[15:0];
				CFG_ORIGIN_Y:   origin_y_q  <= cfg_wdata[15:0];
				CFG_WIDTH:      width_q     <= cfg_wdata[6:0];
				CFG_HEIGHT:     height_q    <= cfg_wdata[6:0];
				CFG_FOREGROUND: fg_q        <= cfg_wdata;
				CFG_BACKGROUND: bg_q        <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// The pipeline never stalls, so a word is taken on every start.
	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// Pattern size clamped to the supported maximum.
	logic [6:0] w_sat, h_sat;
	assign w_sat = (32'(width_q) > MAX_PATTERN_WIDTH) ? 7'(MAX_PATTERN_WIDTH) : width_q;
	assign h_sat = (32'(height_q) > MAX_PATTERN_HEIGHT) ? 7'(MAX_PATTERN_HEIGHT) : height_q;

	// Offsets from the pattern origin and the early classification of the word.
	logic signed [16:0] bx, by;
	side_t              side_in;

	always_comb begin
		bx = 17'(point_x) - 17'(origin_x_q);
		by = 17'(point_y) - 17'(origin_y_q);
		side_in.load   = (operation == OP_LOAD);
		side_in.windex = word_index;
		side_in.wdata  = word_data;
		if (operation == OP_LOAD || w_sat == '0 || h_sat == '0 || !clip_visible) begin
			side_in.kind = KIND_NONE;
		end else if (bx[16] || by[16]) begin
			side_in.kind = KIND_FG;
		end else begin
			side_in.kind = KIND_PATTERN;
		end
	end

	// Stage 1 and the control that follows the remainder pipeline.
	logic        vld_s [1:SIDE_LAST];
	side_t       side_s [1:SIDE_LAST];
	logic [15:0] bx_s1, by_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= SIDE_LAST; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else begin
			vld_s[1] <= accept;
			for (int k = 2; k <= SIDE_LAST; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		side_s[1] <= side_in;
		bx_s1     <= bx[15:0];
		by_s1     <= by[15:0];
		for (int k = 2; k <= SIDE_LAST; k++) begin
			side_s[k] <= side_s[k-1];
		end
	end

	logic [6:0] px, py;

	stps_mod_pipe u_mod (
		.clk   (clk),
		.dvd_x (bx_s1),
		.dvd_y (by_s1),
		.div_x (w_sat),
		.div_y (h_sat),
		.rem_x (px),
		.rem_y (py)
	);

	// Address stage: word address and bit position inside the word.
	logic [6:0]       pitch, col;
	logic [13:0]      prod;
	logic [IDX_W-1:0] idx;
	logic [BW-1:0]    pos;

	always_comb begin
		pitch = 7'((32'(w_sat) + WORD_BITS - 1) / WORD_BITS);
		col   = 7'(32'(px) / WORD_BITS);
		prod  = 14'(py) * 14'(pitch);
		idx   = IDX_W'(prod) + IDX_W'(col);
		pos   = BW'(WORD_BITS - 1) - BW'(32'(px) % WORD_BITS);
	end

	logic          vld_s6, load_s6, inrange_s6;
	kind_t         kind_s6;
	logic [7:0]    windex_s6;
	logic [15:0]   wdata_s6;
	logic [AW-1:0] addr_s6;
	logic [BW-1:0] pos_s6;
	logic [6:0]    px_s6, py_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= vld_s[SIDE_LAST];
		end
	end

	always_ff @(posedge clk) begin
		load_s6    <= side_s[SIDE_LAST].load;
		kind_s6    <= side_s[SIDE_LAST].kind;
		windex_s6  <= side_s[SIDE_LAST].windex;
		wdata_s6   <= side_s[SIDE_LAST].wdata;
		addr_s6    <= AW'(idx);
		inrange_s6 <= (32'(idx) < STIPPLE_DEPTH);
		pos_s6     <= pos;
		px_s6      <= px;
		py_s6      <= py;
	end

	// Loads and reads share this stage, so the store sees words in acceptance order.
	logic                 ram_we, ram_re;
	logic [WORD_BITS-1:0] ram_rdata;

	assign ram_we = vld_s6 && load_s6 && (32'(windex_s6) < STIPPLE_DEPTH);
	assign ram_re = vld_s6 && !load_s6 && inrange_s6 && (kind_s6 == KIND_PATTERN);

	stps_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (STIPPLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(windex_s6)),
		.wdata (WORD_BITS'(wdata_s6)),
		.re    (ram_re),
		.raddr (addr_s6),
		.rdata (ram_rdata)
	);

	logic          vld_s7, inrange_s7;
	kind_t         kind_s7;
	logic [BW-1:0] pos_s7;
	logic [5:0]    px_s7, py_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		inrange_s7 <= inrange_s6;
		kind_s7    <= kind_s6;
		pos_s7     <= pos_s6;
		px_s7      <= px_s6[5:0];
		py_s7      <= py_s6[5:0];
	end

	// Result selection.
	logic        bit_set;
	logic [1:0]  act_nxt;
	logic [31:0] color_nxt;
	logic [5:0]  tx_nxt, ty_nxt;

	always_comb begin
		bit_set   = inrange_s7 && ram_rdata[pos_s7];
		act_nxt   = ACT_NONE;
		color_nxt = '0;
		tx_nxt    = '0;
		ty_nxt    = '0;
		case (kind_s7)
			KIND_FG: begin
				act_nxt   = ACT_COLOR;
				color_nxt = fg_q;
			end
			KIND_PATTERN: begin
				case (fill_mode_q)
					FM_STIPPLE: begin
						if (bit_set) begin
							act_nxt   = ACT_COLOR;
							color_nxt = fg_q;
						end
					end
					FM_OPAQUE: begin
						act_nxt   = ACT_COLOR;
						color_nxt = bit_set ? fg_q : bg_q;
					end
					FM_TILE: begin
						act_nxt = ACT_TILE;
						tx_nxt  = px_s7;
						ty_nxt  = py_s7;
					end
					default: act_nxt = ACT_NONE;
				endcase
			end
			default: act_nxt = ACT_NONE;
		endcase
	end

	logic        done_q;
	logic [1:0]  action_q;
	logic [31:0] color_q;
	logic [5:0]  tile_x_q, tile_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		action_q <= act_nxt;
		color_q  <= color_nxt;
		tile_x_q <= tx_nxt;
		tile_y_q <= ty_nxt;
	end

	assign done   = done_q;
	assign action = action_q;
	assign color  = color_q;
	assign tile_x = tile_x_q;
	assign tile_y = tile_y_q;

endmodule

/* hw/rtl/stps_checker.sv */
// Port-level checker for the stipple and tile pixel select block, bound to the top level.
// Depends on stps_pkg for the latency and action codes.
module stps_checker
	import stps_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        operation,
	input logic        done,
	input logic [1:0]  action,
	input logic [31:0] color,
	input logic [5:0]  tile_x,
	input logic [5:0]  tile_y
);

	logic acc;
	assign acc = start && !busy && arst_n;

	// Every accepted word produces a result a fixed time later.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> ##OUT_LATENCY done)
		else $error("accepted word produced no result");

	// No result word appears without an accepted word behind it.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(acc, OUT_LATENCY))
		else $error("result word without an accepted word");

	// A stipple load never draws anything.
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(acc && operation == OP_LOAD, OUT_LATENCY)) |-> action == ACT_NONE)
		else $error("load word produced a drawing action");

	// Tile coordinates only come with a tile read, color only with a color draw.
	a_field_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && action != ACT_TILE) |-> (tile_x == '0 && tile_y == '0))
		else $error("tile coordinates set outside a tile read");

	a_color_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && action != ACT_COLOR) |-> color == '0)
		else $error("color set outside a color draw");

endmodule

bind stipple_tile_pixel_select stps_checker u_stps_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.operation (operation),
	.done      (done),
	.action    (action),
	.color     (color),
	.tile_x    (tile_x),
	.tile_y    (tile_y)
);
